// File: hdl/mft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mft_pkg
// Shared types and constants for the Manchester frame transmitter.
// ----------------------------------------------------------------------------
package mft_pkg;

    localparam logic [7:0] PREAMBLE_RESET    = 8'hFA;
    localparam int         QUEUE_DEPTH_DEF   = 2;
    localparam logic [3:0] LAST_HALF_BIT     = 4'd15;

    // One queued job: everything the back end needs for one frame byte.
    typedef struct packed {
        logic [7:0] preamble;
        logic       send_preamble;
        logic [7:0] data_byte;
        logic       end_of_frame;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_DATA,
        ST_TAIL
    } t_tx_state;

endpackage

// File: hdl/mft_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mft_in_if
// Byte channel into the transmitter: valid/ready plus frame byte fields.
// ----------------------------------------------------------------------------
interface mft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_frame;

    modport source (output valid, output data_byte, output end_of_frame, input ready);
    modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

// File: hdl/mft_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mft_out_if
// Symbol channel out of the transmitter: valid/ready plus line symbol fields.
// ----------------------------------------------------------------------------
interface mft_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic last_of_run;
    logic idle_marker;

    modport source (output valid, output line_level, output last_of_run,
                    output idle_marker, input ready);
    modport sink   (input valid, input line_level, input last_of_run,
                    input idle_marker, output ready);
endinterface

// File: hdl/mft_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mft_front
// Accepts frame bytes, tracks frame state, and builds queue jobs.
// ----------------------------------------------------------------------------
module mft_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    mft_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_q_push,
    output mft_pkg::t_cmd o_q_cmd
);
    import mft_pkg::*;

    logic       r_frame_open;
    logic       n_frame_open;
    logic [7:0] r_preamble;

    assign i_in.ready = !i_q_full;
    assign o_q_push   = i_in.valid && !i_q_full;

    always_comb begin
        o_q_cmd.preamble      = r_preamble;
        o_q_cmd.send_preamble = !r_frame_open;
        o_q_cmd.data_byte     = i_in.data_byte;
        o_q_cmd.end_of_frame  = i_in.end_of_frame;
        n_frame_open          = r_frame_open;
        if (o_q_push) begin
            // last byte closes the frame, anything else leaves it open
            n_frame_open = !i_in.end_of_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_preamble   <= PREAMBLE_RESET;
        end else begin
            r_frame_open <= n_frame_open;
            if (i_cfg_we) begin
                r_preamble <= i_cfg_data;
            end
        end
    end

endmodule

// File: hdl/mft_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mft_queue
// Small job FIFO between front and back ends.
// ----------------------------------------------------------------------------
module mft_queue #(
    parameter int DEPTH = mft_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mft_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mft_pkg::t_cmd o_cmd
);
    import mft_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hdl/mft_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mft_back
// Serializes queued jobs into Manchester half-bit symbols, one per cycle unless
// the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
module mft_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  mft_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    mft_out_if.source     o_out
);
    import mft_pkg::*;

    t_tx_state  r_state, n_state;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_data,  n_data;
    logic       r_eof,   n_eof;
    logic [3:0] r_idx,   n_idx;

    logic r_out_valid, n_out_valid;
    logic r_level,     n_level;
    logic r_last,      n_last;
    logic r_idle,      n_idle;

    logic w_adv;
    logic w_done;
    logic w_load;
    logic w_sym_level;
    logic w_sym_last;
    logic w_sym_idle;

    assign w_adv = !r_out_valid || o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.line_level  = r_level;
    assign o_out.last_of_run = r_last;
    assign o_out.idle_marker = r_idle;

    always_comb begin
        n_state     = r_state;
        n_shift     = r_shift;
        n_data      = r_data;
        n_eof       = r_eof;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_level     = r_level;
        n_last      = r_last;
        n_idle      = r_idle;
        w_done      = 1'b0;
        w_sym_level = r_idx[0] ? !r_shift[7] : r_shift[7];
        w_sym_last  = 1'b0;
        w_sym_idle  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                w_done = 1'b1;
            end
            ST_PRE: begin
                if (w_adv) begin
                    n_idx   = r_idx + 1'b1;
                    n_shift = r_idx[0] ? {r_shift[6:0], 1'b0} : r_shift;
                    if (r_idx == LAST_HALF_BIT) begin
                        n_state = ST_DATA;
                        n_shift = r_data;
                    end
                end
            end
            ST_DATA: begin
                w_sym_last = (r_idx == LAST_HALF_BIT) && !r_eof;
                if (w_adv) begin
                    n_idx   = r_idx + 1'b1;
                    n_shift = r_idx[0] ? {r_shift[6:0], 1'b0} : r_shift;
                    if (r_idx == LAST_HALF_BIT) begin
                        if (r_eof) begin
                            n_state = ST_TAIL;
                        end else begin
                            w_done = 1'b1;
                        end
                    end
                end
            end
            ST_TAIL: begin
                w_sym_level = 1'b0;
                w_sym_last  = 1'b1;
                w_sym_idle  = 1'b1;
                w_done      = w_adv;
            end
            default: begin
                w_done = 1'b1;
            end
        endcase

        // output stage takes a symbol whenever it frees up
        if (w_adv) begin
            n_out_valid = (r_state != ST_IDLE);
            n_level     = w_sym_level;
            n_last      = w_sym_last;
            n_idle      = w_sym_idle;
        end

        w_load = w_done && i_q_valid && (w_adv || r_state == ST_IDLE);
        if (w_done && !w_load) begin
            n_state = ST_IDLE;
        end
        if (w_load) begin
            n_state = i_q_cmd.send_preamble ? ST_PRE : ST_DATA;
            n_shift = i_q_cmd.send_preamble ? i_q_cmd.preamble : i_q_cmd.data_byte;
            n_data  = i_q_cmd.data_byte;
            n_eof   = i_q_cmd.end_of_frame;
            n_idx   = '0;
        end
        o_q_pop = w_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_data  <= n_data;
        r_eof   <= n_eof;
        r_idx   <= n_idx;
        r_level <= n_level;
        r_last  <= n_last;
        r_idle  <= n_idle;
    end

endmodule

// File: hdl/manchester_frame_transmitter.sv
`timescale 1ns / 1ps
// First symbol path: queue register, back-end state register, output register.
// Throughput: one half-bit symbol per cycle from the back-end serializer unless
//   output stalls; a byte is 16 symbols (32 opening a frame, +1 closing one).
// The job queue lets the next byte transfer while the current one is still sent.
// Reset (synchronous, active low): no frame open, queue empty, preamble = 0xFA.
// ----------------------------------------------------------------------------
// manchester_frame_transmitter
// Manchester line coder for framed byte streams with a programmable preamble.
// ----------------------------------------------------------------------------
module manchester_frame_transmitter #(
    parameter int QUEUE_DEPTH = mft_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    mft_in_if.sink     i_in,
    mft_out_if.source  o_out
);
    import mft_pkg::*;

    // front -> queue
    logic w_push;
    logic w_full;
    t_cmd w_push_cmd;

    // queue -> back
    logic w_pop;
    logic w_q_valid;
    t_cmd w_q_cmd;

    // Front end: owns the preamble register and the frame-open flag, and
    // decides per byte whether a preamble must be sent first.
    mft_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (w_full),
        .o_q_push   (w_push),
        .o_q_cmd    (w_push_cmd)
    );

    // Job queue: decouples byte transfers from symbol output backpressure.
    mft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // Back end: preamble, data bits MSB first (level then inverse), and the
    // trailing low idle symbol at end of frame; last_of_run marks the final
    // symbol of each job. Next job loads on the same cycle the last symbol goes.
    mft_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_pop),
        .o_out     (o_out)
    );

endmodule
